// File: hdl/pcfc_pkg.sv
// pcfc_pkg: shared types and constants for the pyro channel fire controller.
// No dependencies.

package pcfc_pkg;

    // command codes carried in s_tuser
    localparam logic [1:0] OP_TICK   = 2'd0;
    localparam logic [1:0] OP_FIRE   = 2'd1;
    localparam logic [1:0] OP_USAGE  = 2'd2;
    localparam logic [1:0] OP_SAMPLE = 2'd3;

    // configuration register indexes
    localparam logic [2:0] REG_USAGE_CH1 = 3'd0;
    localparam logic [2:0] REG_USAGE_CH4 = 3'd3;
    localparam logic [2:0] REG_FIRE_TIME = 3'd4;

    localparam int ROLE_REGS    = 4;
    localparam int MAX_CHANNELS = 16;
    localparam int PADS_W       = 4;
    localparam int ROLE_W       = 3;
    localparam int DUR_W        = 16;
    localparam int CH_W         = 3;
    localparam int CFG_IDX_W    = 3;

    localparam logic [DUR_W-1:0] FIRE_TIME_RST = 16'd1000;
    localparam int GREEN_ON_MS = 100;
    localparam int RED_ON_MS   = 400;

    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 16;

    // per-channel command from the decoder
    typedef struct packed {
        logic             tick;
        logic             start;
        logic [DUR_W-1:0] dur;
    } chan_cmd_t;

    // status block to top level
    typedef struct packed {
        logic [PADS_W-1:0] present;
        logic              continuity_ok;
        logic              green;
        logic              red;
    } status_t;

endpackage

// File: hdl/pcfc_channel.sv
// pcfc_channel: one-shot timer for a single igniter channel.
// Depends on pcfc_pkg.

module pcfc_channel
(
    input  logic                clk,
    input  logic                rst_n,
    input  pcfc_pkg::chan_cmd_t cmd,
    output logic                trig_next
);

    logic [pcfc_pkg::DUR_W-1:0] remaining_reg;
    logic [pcfc_pkg::DUR_W-1:0] remaining_next;
    logic                       trig_reg;

    always_comb
    begin
        remaining_next = remaining_reg;
        trig_next      = trig_reg;
        if (cmd.start)
        begin
            remaining_next = cmd.dur;
            trig_next      = 1'b1;
        end
        else if (cmd.tick && trig_reg)
        begin
            if (remaining_reg <= pcfc_pkg::DUR_W'(1))
            begin
                remaining_next = '0;
                trig_next      = 1'b0;
            end
            else
            begin
                remaining_next = remaining_reg - pcfc_pkg::DUR_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            remaining_reg <= '0;
            trig_reg      <= 1'b0;
        end
        else
        begin
            remaining_reg <= remaining_next;
            trig_reg      <= trig_next;
        end
    end

endmodule

// File: hdl/pcfc_status.sv
// pcfc_status: continuity latch, continuity check and indicator blink cycle.
// Depends on pcfc_pkg.

module pcfc_status #(
    parameter int CHANNELS        = 4,
    parameter int BLINK_PERIOD_MS = 500
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        tick,
    input  logic                        sample,
    input  logic [pcfc_pkg::PADS_W-1:0] pads,
    input  logic [CHANNELS-1:0]         used,
    output pcfc_pkg::status_t           status
);

    localparam int PHASE_W = $clog2(BLINK_PERIOD_MS);
    localparam logic [pcfc_pkg::PADS_W-1:0] PAD_MASK =
        (CHANNELS >= pcfc_pkg::PADS_W) ? '1 : pcfc_pkg::PADS_W'((1 << CHANNELS) - 1);

    logic [pcfc_pkg::PADS_W-1:0]       present_reg;
    logic [pcfc_pkg::PADS_W-1:0]       present_next;
    logic [PHASE_W-1:0]                phase_reg;
    logic [PHASE_W-1:0]                phase_next;
    logic [PHASE_W:0]                  phase_inc;
    logic                              ok_reg;
    logic                              ok_next;
    logic [pcfc_pkg::MAX_CHANNELS-1:0] seen_ext;
    logic                              cont_ok;

    // pads are active low
    assign present_next = sample ? (~pads & PAD_MASK) : present_reg;

    // channels beyond the pad field never see an igniter
    assign seen_ext = pcfc_pkg::MAX_CHANNELS'(present_next);
    assign cont_ok  = (used == seen_ext[CHANNELS-1:0]);

    assign phase_inc = {1'b0, phase_reg} + (PHASE_W+1)'(1);

    always_comb
    begin
        phase_next = phase_reg;
        ok_next    = ok_reg;
        if (tick)
        begin
            if (32'(phase_inc) >= 32'(BLINK_PERIOD_MS))
            begin
                phase_next = '0;
                ok_next    = cont_ok;
            end
            else
            begin
                phase_next = phase_inc[PHASE_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            present_reg <= '0;
            phase_reg   <= '0;
            ok_reg      <= 1'b0;
        end
        else
        begin
            present_reg <= present_next;
            phase_reg   <= phase_next;
            ok_reg      <= ok_next;
        end
    end

    assign status.present       = present_next;
    assign status.continuity_ok = cont_ok;
    assign status.green         = ok_next  && (32'(phase_next) < pcfc_pkg::GREEN_ON_MS);
    assign status.red           = !ok_next && (32'(phase_next) < pcfc_pkg::RED_ON_MS);

endmodule

// File: hdl/pyro_channel_fire_controller.sv
// pyro_channel_fire_controller: top level, command decode, role registers and result register.
// Depends on pcfc_pkg, pcfc_channel, pcfc_status.

// Usage
//   Slave stream (s_*) carries one command word per beat: s_tuser selects a
//   millisecond tick, a fire of one channel, a fire by role, or a continuity
//   sample. Every accepted word produces exactly one result word on the
//   master stream (m_*) with trigger levels, channels just fired, latched
//   igniter presence, the continuity verdict and the two indicator levels.
//   Latency: the result is valid in the cycle after the word is accepted.
//   Throughput: one word per cycle unless stalled; all channel timers and the status logic
//   update in parallel in the accept cycle, set by the single result register.
//   Stall: while a result waits, s_tready follows m_tready, so a new word is
//   taken in the same cycle the waiting result leaves; with m_tready low and
//   a result held, input stalls and no state changes.
//   Reset: triggers off, countdowns zero, no igniter seen, indicator phase
//   zero with red lit first; roles reset to unused, fire time to 1000 ms.
//   Configuration: cfg_we writes register cfg_index (0..3 channel roles,
//   4 fire time); other indexes are ignored. Write only while idle.

module pyro_channel_fire_controller #(
    parameter int CHANNELS        = 4,
    parameter int BLINK_PERIOD_MS = 500
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    // slave stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [2:0] channel, [18:3] pulse_ms, [21:19] usage, [25:22] sense_pads, rest zero
    input  logic [pcfc_pkg::IN_DATA_W-1:0]      s_tdata,
    // [1:0] op
    input  logic [1:0]                          s_tuser,
    // master stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [3:0] triggers, [7:4] fired, [11:8] present, [12] continuity_ok,
    // [13] green_led, [14] red_led, [15] zero
    output logic [pcfc_pkg::OUT_DATA_W-1:0]     m_tdata,
    // configuration
    input  logic                                cfg_we,
    input  logic [pcfc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [pcfc_pkg::DUR_W-1:0]          cfg_wdata
);

    logic                              accept;
    logic [1:0]                        op;
    logic [pcfc_pkg::CH_W-1:0]         channel;
    logic [pcfc_pkg::DUR_W-1:0]        pulse_ms;
    logic [pcfc_pkg::ROLE_W-1:0]       usage;
    logic [pcfc_pkg::PADS_W-1:0]       sense_pads;
    logic                              is_tick;
    logic                              is_fire;
    logic                              is_usage;
    logic                              is_sample;

    logic [pcfc_pkg::ROLE_W-1:0]       usage_reg [pcfc_pkg::ROLE_REGS];
    logic [pcfc_pkg::DUR_W-1:0]        fire_time_reg;

    logic [CHANNELS-1:0]               used;
    logic [CHANNELS-1:0]               start_vec;
    logic [CHANNELS-1:0]               trig_vec;
    logic [pcfc_pkg::MAX_CHANNELS-1:0] start_ext;
    logic [pcfc_pkg::MAX_CHANNELS-1:0] trig_ext;
    pcfc_pkg::status_t                 status;

    logic                              out_valid_reg;
    logic [pcfc_pkg::OUT_DATA_W-1:0]   out_data_reg;
    logic [pcfc_pkg::OUT_DATA_W-1:0]   out_data_next;

    // output register frees itself when the receiver takes the word
    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    assign op          = s_tuser;
    assign channel     = s_tdata[2:0];
    assign pulse_ms    = s_tdata[18:3];
    assign usage       = s_tdata[21:19];
    assign sense_pads  = s_tdata[25:22];

    assign is_tick   = accept && (op == pcfc_pkg::OP_TICK);
    assign is_fire   = accept && (op == pcfc_pkg::OP_FIRE);
    assign is_usage  = accept && (op == pcfc_pkg::OP_USAGE) && (usage != '0);
    assign is_sample = accept && (op == pcfc_pkg::OP_SAMPLE);

    // role registers and fire time
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < pcfc_pkg::ROLE_REGS; i++)
            begin
                usage_reg[i] <= '0;
            end
            fire_time_reg <= pcfc_pkg::FIRE_TIME_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index) inside
                [pcfc_pkg::REG_USAGE_CH1:pcfc_pkg::REG_USAGE_CH4]:
                    usage_reg[cfg_index[1:0]] <= cfg_wdata[pcfc_pkg::ROLE_W-1:0];
                pcfc_pkg::REG_FIRE_TIME:
                    fire_time_reg <= cfg_wdata;
                default:
                    ;
            endcase
        end
    end

    // one timer per channel
    for (genvar g = 0; g < CHANNELS; g++)
    begin : g_chan
        logic [pcfc_pkg::ROLE_W-1:0] role;
        pcfc_pkg::chan_cmd_t         cmd;
        logic                        hit_fire;
        logic                        hit_usage;

        // channels above four have no role register: always unused
        if (g < pcfc_pkg::ROLE_REGS)
        begin : g_role
            assign role = usage_reg[g];
        end
        else
        begin : g_norole
            assign role = '0;
        end

        // widen before compare so channel 0 never aliases a high channel
        assign hit_fire  = is_fire && ({2'b00, channel} == 5'(g + 1));
        assign hit_usage = is_usage && (role == usage);

        assign used[g]      = (role != '0);
        assign start_vec[g] = hit_fire || hit_usage;

        assign cmd.tick  = is_tick;
        assign cmd.start = start_vec[g];
        assign cmd.dur   = hit_fire ? pulse_ms : fire_time_reg;

        pcfc_channel u_chan
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .cmd       (cmd),
            .trig_next (trig_vec[g])
        );
    end

    pcfc_status #(
        .CHANNELS        (CHANNELS),
        .BLINK_PERIOD_MS (BLINK_PERIOD_MS)
    ) u_status
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .tick   (is_tick),
        .sample (is_sample),
        .pads   (sense_pads),
        .used   (used),
        .status (status)
    );

    // only the first four channels are visible on the result word
    assign start_ext = pcfc_pkg::MAX_CHANNELS'(start_vec);
    assign trig_ext  = pcfc_pkg::MAX_CHANNELS'(trig_vec);

    assign out_data_next = {1'b0, status.red, status.green, status.continuity_ok,
                            status.present, start_ext[3:0], trig_ext[3:0]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            out_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// File: hdl/pcfc_checker.sv
// pcfc_checker: port-level assertions for the pyro channel fire controller, bound to the top.
// Depends on pyro_channel_fire_controller.

module pcfc_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    // held result word must not change
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // an empty output register always takes input
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output register");

    // a channel fired by this word has its trigger high
    a_fired: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[7:4] & ~m_tdata[3:0]) == 4'b0000)
        else $error("fired channel without trigger");

    // green and red are never lit together
    a_leds: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[13] && m_tdata[14]))
        else $error("both indicators lit");

endmodule

bind pyro_channel_fire_controller pcfc_checker u_pcfc_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
